[rtl/core/mtma_pkg.sv]
// Shared types and constants of the multichannel triple moving average block.
package mtma_pkg;

  localparam int unsigned CHANNELS_DEF      = 8;
  localparam int unsigned HISTORY_DEPTH_DEF = 64;
  localparam int unsigned SAMPLE_BITS_DEF   = 16;

  localparam int unsigned MODE_W   = 1;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned WIN_W    = 6;
  localparam int unsigned SUM_W    = 22;
  localparam int unsigned AVG_W    = 16;
  localparam int unsigned NUM_W    = SUM_W + 2;
  localparam int unsigned DEN_W    = WIN_W + 1;
  localparam int unsigned RAM_AW   = 14;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned NUM_WIN  = 3;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_INIT   = 1'b1;

  localparam logic [1:0] REG_WIN_DISPLAY   = 2'd0;
  localparam logic [1:0] REG_WIN_CALIBRATE = 2'd1;
  localparam logic [1:0] REG_WIN_MEASURE   = 2'd2;

  localparam logic [WIN_W-1:0] WIN_DISPLAY_RST   = 6'd8;
  localparam logic [WIN_W-1:0] WIN_CALIBRATE_RST = 6'd16;
  localparam logic [WIN_W-1:0] WIN_MEASURE_RST   = 6'd32;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_FILL,
    S_START,
    S_DIVIDE,
    S_DONE
  } mtma_state_e;

  // Write and read request to the history memory.
  typedef struct packed {
    logic                 we;
    logic [RAM_AW-1:0]    waddr;
    logic [VALUE_W-1:0]   wdata;
    logic                 re;
    logic [RAM_AW-1:0]    raddr;
  } mtma_ram_req_t;

endpackage

[rtl/core/mtma_if.sv]
// Channel interfaces for input items and result items.
interface mtma_in_if import mtma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [CHAN_W-1:0]  channel;
  logic [VALUE_W-1:0] sample_value;

  modport source (output valid, mode, channel, sample_value, input ready);
  modport sink   (input valid, mode, channel, sample_value, output ready);
endinterface

interface mtma_out_if import mtma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel_out;
  logic [AVG_W-1:0]  avg_display;
  logic [AVG_W-1:0]  avg_calibrate;
  logic [AVG_W-1:0]  avg_measure;

  modport source (output valid, channel_out, avg_display, avg_calibrate, avg_measure,
                  input ready);
  modport sink   (input valid, channel_out, avg_display, avg_calibrate, avg_measure,
                  output ready);
endinterface

[rtl/core/mtma_hist_ram.sv]
// Sample history memory: one write port, one read port, registered read data.
module mtma_hist_ram import mtma_pkg::*; #(
  parameter int unsigned WORDS       = CHANNELS_DEF * HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  mtma_ram_req_t          req_i,
  output logic [SAMPLE_BITS-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(WORDS);

  logic [SAMPLE_BITS-1:0] mem [WORDS];
  logic [SAMPLE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata[SAMPLE_BITS-1:0];
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mtma_avg_div.sv]
// Iterative rounded average: floor((2*sum + w) / (2*w)), one quotient bit per cycle.
module mtma_avg_div import mtma_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [WIN_W-1:0] win_i,
  output logic             done_o,
  output logic [AVG_W-1:0] avg_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             zero_q, zero_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    zero_d = zero_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NUM_W-1]};
    if (start_i) begin
      num_d  = {1'b0, sum_i, 1'b0} + NUM_W'(win_i);
      den_d  = {win_i, 1'b0};
      rem_d  = '0;
      quo_d  = '0;
      zero_d = (win_i == '0);
      cnt_d  = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      num_d = {num_q[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  // A zero window reports zero; a quotient above the output range saturates.
  assign avg_o  = zero_q ? '0 :
                  (quo_q[NUM_W-1:AVG_W] != '0) ? '1 : quo_q[AVG_W-1:0];

endmodule

[rtl/core/multichannel_triple_moving_average_top.sv]
// Top level of the multichannel triple moving average block.
//
//  Port      Direction  Carries
//  sample_i  in         mode, channel, sample_value
//  result_o  out        channel_out, avg_display, avg_calibrate, avg_measure
//  APB       in/out     window registers at 0x0, 0x4, 0x8
//
// A sample transaction runs three history reads through the single memory read port, one
// update, and a 24-step divide before a valid result is presented.
// An init transaction fills its HISTORY_DEPTH channel words via the one memory write port.
// After reset a clearing pass zeroes all CHANNELS * HISTORY_DEPTH words of the history;
// no transaction is accepted during it. A result waits in the output register until taken.
module multichannel_triple_moving_average_top import mtma_pkg::*; #(
  parameter int unsigned CHANNELS      = CHANNELS_DEF,
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mtma_in_if.sink            sample_i,
  mtma_out_if.source         result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned WORDS = CHANNELS * HISTORY_DEPTH;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned WIN_N = 1 << WIN_W;

  // Window registers.
  logic [WIN_W-1:0] win_q [NUM_WIN];
  logic [1:0]       reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= WIN_DISPLAY_RST;
      win_q[1] <= WIN_CALIBRATE_RST;
      win_q[2] <= WIN_MEASURE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIN_DISPLAY:   win_q[0] <= pwdata[WIN_W-1:0];
        REG_WIN_CALIBRATE: win_q[1] <= pwdata[WIN_W-1:0];
        REG_WIN_MEASURE:   win_q[2] <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIN_DISPLAY:   prdata = PDATA_W'(win_q[0]);
      REG_WIN_CALIBRATE: prdata = PDATA_W'(win_q[1]);
      REG_WIN_MEASURE:   prdata = PDATA_W'(win_q[2]);
      default:           prdata = '0;
    endcase
  end

  // Look-back distance of each window value, the window modulo the history depth.
  logic [PTR_W-1:0] dist_tab [WIN_N];
  for (genvar g = 0; g < WIN_N; g++) begin : g_dist
    assign dist_tab[g] = PTR_W'(g % HISTORY_DEPTH);
  end

  // Per-channel pointers and running sums.
  logic [PTR_W-1:0] wptr_q [CHANNELS];
  logic [SUM_W-1:0] sum_q  [CHANNELS][NUM_WIN];

  mtma_state_e          state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [PTR_W-1:0]     idx_q, idx_d;
  logic [1:0]           rd_q, rd_d;
  logic [CH_W-1:0]      ch_q;
  logic [CHAN_W-1:0]    ch_out_q;
  logic [SAMPLE_BITS-1:0] val_q;
  logic [SAMPLE_BITS-1:0] old_q [2];
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SAMPLE_BITS-1:0] old_v [NUM_WIN];
  logic [AW-1:0]        base;
  logic [PTR_W-1:0]     back_ptr;
  logic [PTR_W-1:0]     dist_rd;
  logic                 accept;
  logic                 upd_en, init_en, div_start, out_load;
  logic                 div_done [NUM_WIN];
  logic [AVG_W-1:0]     div_avg  [NUM_WIN];
  mtma_ram_req_t        ram_req;

  logic                 out_valid_q;
  logic [CHAN_W-1:0]    out_ch_q;
  logic [AVG_W-1:0]     out_avg_q [NUM_WIN];

  assign accept = sample_i.valid && sample_i.ready;
  assign base   = AW'(ch_q) * AW'(HISTORY_DEPTH);

  assign dist_rd  = dist_tab[win_q[rd_q]];
  assign back_ptr = (wptr_q[ch_q] >= dist_rd) ? PTR_W'(wptr_q[ch_q] - dist_rd)
                                              : PTR_W'(wptr_q[ch_q] + HISTORY_DEPTH - dist_rd);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    rd_d      = rd_q;
    upd_en    = 1'b0;
    init_en   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    ram_req   = '0;
    sample_i.ready = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = RAM_AW'(clr_q);
        clr_d         = clr_q + 1'b1;
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        sample_i.ready = 1'b1;
        rd_d  = '0;
        idx_d = '0;
        if (sample_i.valid) begin
          state_d = (sample_i.mode == MODE_INIT) ? S_FILL : S_READ;
        end
      end
      S_READ: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = RAM_AW'(base + AW'(back_ptr));
        rd_d          = rd_q + 1'b1;
        if (rd_q == 2'd2) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = RAM_AW'(base + AW'(wptr_q[ch_q]));
        ram_req.wdata = VALUE_W'(val_q);
        upd_en        = 1'b1;
        state_d       = S_START;
      end
      S_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = RAM_AW'(base + AW'(idx_q));
        ram_req.wdata = VALUE_W'(val_q);
        idx_d         = idx_q + 1'b1;
        if (idx_q == PTR_W'(HISTORY_DEPTH - 1)) begin
          init_en = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done[0]) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      rd_q    <= rd_d;
    end
  end

  // Accepted transaction and captured history reads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (32'(sample_i.channel) >= CHANNELS) begin
        ch_q     <= '0;
        ch_out_q <= '0;
      end else begin
        ch_q     <= CH_W'(sample_i.channel);
        ch_out_q <= sample_i.channel;
      end
      val_q <= sample_i.sample_value[SAMPLE_BITS-1:0];
    end
    if (state_q == S_READ && rd_q != 2'd0) begin
      old_q[rd_q[1]] <= rdata;
    end
  end

  // A zero look-back distance reads the sample being written, so the new value is used.
  always_comb begin
    old_v[0] = (dist_tab[win_q[0]] == '0) ? val_q : old_q[0];
    old_v[1] = (dist_tab[win_q[1]] == '0) ? val_q : old_q[1];
    old_v[2] = (dist_tab[win_q[2]] == '0) ? val_q : rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wptr_q[c] <= '0;
        for (int w = 0; w < NUM_WIN; w++) begin
          sum_q[c][w] <= '0;
        end
      end
    end else if (upd_en) begin
      wptr_q[ch_q] <= (wptr_q[ch_q] == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                  : wptr_q[ch_q] + 1'b1;
      for (int w = 0; w < NUM_WIN; w++) begin
        sum_q[ch_q][w] <= sum_q[ch_q][w] + SUM_W'(val_q) - SUM_W'(old_v[w]);
      end
    end else if (init_en) begin
      wptr_q[ch_q] <= '0;
      for (int w = 0; w < NUM_WIN; w++) begin
        sum_q[ch_q][w] <= SUM_W'(win_q[w]) * SUM_W'(val_q);
      end
    end
  end

  mtma_hist_ram #(
    .WORDS       (WORDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  for (genvar w = 0; w < NUM_WIN; w++) begin : g_div
    mtma_avg_div u_avg_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .sum_i   (sum_q[ch_q][w]),
      .win_i   (win_q[w]),
      .done_o  (div_done[w]),
      .avg_o   (div_avg[w])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q <= ch_out_q;
      for (int w = 0; w < NUM_WIN; w++) begin
        out_avg_q[w] <= div_avg[w];
      end
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.channel_out   = out_ch_q;
  assign result_o.avg_display   = out_avg_q[0];
  assign result_o.avg_calibrate = out_avg_q[1];
  assign result_o.avg_measure   = out_avg_q[2];

`ifndef SYNTHESIS
  a_no_write_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVIDE) |-> !ram_req.we)
    else $error("history written during divide");

  a_done_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done[0] |-> (state_q == S_DIVIDE))
    else $error("divider finished outside divide state");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_en |-> (32'(wptr_q[ch_q]) < HISTORY_DEPTH))
    else $error("write pointer out of range");

  a_mode_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sample_i.mode == MODE_SAMPLE) |=> (state_q == S_READ))
    else $error("sample transaction did not start reads");
`endif

endmodule
